### hdl/bezier_path_point_eval_defines.svh
// assertion macros shared by the bezier path point evaluator
// depends on nothing; included by files that carry assertions
`ifndef BEZIER_PATH_POINT_EVAL_DEFINES_SVH
`define BEZIER_PATH_POINT_EVAL_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define BPE_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("bpe check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BPE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("bpe check failed");

`endif

### hdl/bpe_pkg.sv
// package for the bezier path point evaluator: constants, types
// depends on nothing
package bpe_pkg;

  localparam int MaxPointsDef = 64;
  localparam int CoordBitsDef = 32;
  localparam int TIdxW        = 6;
  localparam int CoordW       = 32;
  localparam int TimeW        = 17;
  localparam int CntW         = 7;
  localparam logic [16:0] TimeOne = 17'd65536;

  // action codes
  localparam logic ActWrite = 1'b0;
  localparam logic ActEval  = 1'b1;

  // vector selector codes
  localparam logic [1:0] VecPos     = 2'd0;
  localparam logic [1:0] VecCtrlIn  = 2'd1;
  localparam logic [1:0] VecCtrlOut = 2'd2;

  // register indexes
  localparam logic [1:0] RegLinear = 2'd0;
  localparam logic [1:0] RegWrap   = 2'd1;
  localparam logic [1:0] RegCount  = 2'd2;

  typedef struct packed {
    logic linear_mode;
    logic wrap_enable;
    logic [CntW-1:0] point_count;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic [TIdxW-1:0] point_index;
    logic [1:0] which_vector;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
    logic [TimeW-1:0] seg_time;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic ok;
  } out_item_t;

  // per-stage control carried with an item
  typedef struct packed {
    logic ok;
    logic zero;
    logic end_only;
    logic lin;
  } ctl_t;

endpackage

### hdl/bpe_stream_if.sv
// valid/ready channel interface carrying one item
// depends on nothing; payload type given as a parameter
interface bpe_stream_if #(parameter type item_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/bpe_store.sv
// point store: position, incoming and outgoing control memories
// depends on bpe_pkg; read data registered; positions read at both addresses, controls at one each
module bpe_store #(
  parameter int MAX_POINTS = bpe_pkg::MaxPointsDef,
  parameter int COORD_BITS = bpe_pkg::CoordBitsDef,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic clk,
  input  logic en,
  input  logic wr_en,
  input  logic [1:0] wr_sel,
  input  logic [AW-1:0] wr_addr,
  input  logic [3*bpe_pkg::CoordW-1:0] wr_data,
  input  logic [AW-1:0] rd_a,
  input  logic [AW-1:0] rd_b,
  output logic [3*bpe_pkg::CoordW-1:0] p0_q,
  output logic [3*bpe_pkg::CoordW-1:0] c0_q,
  output logic [3*bpe_pkg::CoordW-1:0] c1_q,
  output logic [3*bpe_pkg::CoordW-1:0] p1_q
);
  localparam int CW = bpe_pkg::CoordW;
  localparam int SW = (COORD_BITS < CW) ? COORD_BITS : CW;

  logic [3*CW-1:0] pos_mem [MAX_POINTS];
  logic [3*CW-1:0] cin_mem [MAX_POINTS];
  logic [3*CW-1:0] cout_mem [MAX_POINTS];
  logic [3*CW-1:0] wr_ext;

  // keep the low coordinate bits, sign extended
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wr_ext[a*CW +: CW] = CW'($signed(wr_data[a*CW +: SW]));
    end
  end

  // writes
  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == bpe_pkg::VecPos) pos_mem[wr_addr] <= wr_ext;
    if (wr_en && wr_sel == bpe_pkg::VecCtrlIn) cin_mem[wr_addr] <= wr_ext;
    if (wr_en && wr_sel == bpe_pkg::VecCtrlOut) cout_mem[wr_addr] <= wr_ext;
  end

  // registered reads, held on stall
  always_ff @(posedge clk) begin
    if (en) begin
      p0_q <= pos_mem[rd_a];
      c0_q <= cout_mem[rd_a];
      p1_q <= pos_mem[rd_b];
      c1_q <= cin_mem[rd_b];
    end
  end
endmodule

### hdl/bpe_weights.sv
// bernstein weight pipeline: two registered multiply stages
// depends on bpe_pkg; advances when en is high
module bpe_weights (
  input  logic clk,
  input  logic en,
  input  logic [16:0] t_in,
  output logic [17:0] w0_q,
  output logic [17:0] w1_q,
  output logic [17:0] w2_q,
  output logic [17:0] w3_q,
  output logic [16:0] t_q
);
  logic [16:0] t1_r, u1_r, uu_r, tt_r;
  logic [16:0] u_nxt;
  logic [33:0] uu_nxt, tt_nxt;
  logic [35:0] w0_p, w1_p, w2_p, w3_p;

  assign u_nxt  = bpe_pkg::TimeOne - t_in;
  assign uu_nxt = u_nxt * u_nxt;
  assign tt_nxt = t_in * t_in;

  // stage one: squares
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_in;
      u1_r <= u_nxt;
      uu_r <= uu_nxt[32:16];
      tt_r <= tt_nxt[32:16];
    end
  end

  assign w0_p = 36'(uu_r) * 36'(u1_r);
  assign w1_p = 36'(uu_r) * 36'(t1_r) * 36'd3;
  assign w2_p = 36'(u1_r) * 36'(tt_r) * 36'd3;
  assign w3_p = 36'(tt_r) * 36'(t1_r);

  // stage two: cubic weights
  always_ff @(posedge clk) begin
    if (en) begin
      w0_q <= w0_p[33:16];
      w1_q <= w1_p[33:16];
      w2_q <= w2_p[33:16];
      w3_q <= w3_p[33:16];
      t_q  <= t1_r;
    end
  end
endmodule

### hdl/bezier_path_point_eval.sv
// bezier path point evaluator, top level
// depends on bpe_pkg, bpe_stream_if, bpe_store, bpe_weights, defines header
//
// channel | dir | handshake   | payload
// in_     | in  | valid/ready | action, point_index, which_vector, xyz, seg_time
// out_    | out | valid/ready | out_x, out_y, out_z, ok
// cfg_    | in  | apb         | linear_mode, wrap_enable, point_count
//
// one item per cycle while out_ready does not stall; the result is offered
// after the store read, compare, product and sum stages
// reset clears valid bits and config registers; store contents undefined until written
// a stall on out_ready freezes all stages; nothing is lost or repeated
`include "bezier_path_point_eval_defines.svh"
module bezier_path_point_eval #(
  parameter int MAX_POINTS = bpe_pkg::MaxPointsDef,
  parameter int COORD_BITS = bpe_pkg::CoordBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  bpe_stream_if.sink   in_ch,
  bpe_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int CW = bpe_pkg::CoordW;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  bpe_pkg::cfg_t cfg_r;
  bpe_pkg::in_item_t it;
  logic en;
  logic [3:0] v_r;

  // configuration registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_mode <= 1'b0;
      cfg_r.wrap_enable <= 1'b0;
      cfg_r.point_count <= 7'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        bpe_pkg::RegLinear: cfg_r.linear_mode <= cfg_pwdata[0];
        bpe_pkg::RegWrap:   cfg_r.wrap_enable <= cfg_pwdata[0];
        bpe_pkg::RegCount:  cfg_r.point_count <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      bpe_pkg::RegLinear: cfg_prdata = {31'd0, cfg_r.linear_mode};
      bpe_pkg::RegWrap:   cfg_prdata = {31'd0, cfg_r.wrap_enable};
      bpe_pkg::RegCount:  cfg_prdata = {25'd0, cfg_r.point_count};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // pipeline advances unless the output is held
  assign en = !(v_r[3] && !out_ch.ready);
  assign in_ch.ready = en;
  assign it = in_ch.data;

  // stage 0 decode
  logic [NW-1:0] cnt;
  logic [16:0] t_sat;
  logic in_rng, is_last, wr_ok;
  logic [AW-1:0] idx_a, idx_b;
  bpe_pkg::ctl_t c0_nxt, c1_r, c2_r, c3_r;

  always_comb begin
    cnt = (32'(cfg_r.point_count) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                : NW'(cfg_r.point_count);
    t_sat = (it.seg_time > bpe_pkg::TimeOne) ? bpe_pkg::TimeOne : it.seg_time;
    in_rng = 32'(it.point_index) < 32'(cnt);
    is_last = 32'(it.point_index) + 1 == 32'(cnt);
    wr_ok = (it.which_vector != 2'd3) && (32'(it.point_index) < MAX_POINTS);
    idx_a = AW'(it.point_index);
    idx_b = (is_last && cfg_r.wrap_enable) ? '0 : (is_last ? idx_a : AW'(idx_a + 1'b1));
    c0_nxt.ok = (it.action == bpe_pkg::ActWrite) ? wr_ok : in_rng;
    c0_nxt.zero = (it.action == bpe_pkg::ActWrite) || !in_rng;
    c0_nxt.end_only = is_last && !cfg_r.wrap_enable;
    c0_nxt.lin = cfg_r.linear_mode;
  end

  logic [3*CW-1:0] p0_q, cc0_q, cc1_q, p1_q;
  bpe_store #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_store (
    .clk(clk), .en(en),
    .wr_en(in_ch.valid && en && it.action == bpe_pkg::ActWrite && wr_ok),
    .wr_sel(it.which_vector), .wr_addr(idx_a),
    .wr_data({it.in_z, it.in_y, it.in_x}),
    .rd_a(idx_a), .rd_b(idx_b),
    .p0_q(p0_q), .c0_q(cc0_q), .c1_q(cc1_q), .p1_q(p1_q)
  );

  logic [17:0] w0, w1, w2, w3;
  logic [16:0] t2;
  bpe_weights u_wt (
    .clk(clk), .en(en), .t_in(t_sat),
    .w0_q(w0), .w1_q(w1), .w2_q(w2), .w3_q(w3), .t_q(t2)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[2:0], in_ch.valid};
  end

  // stage 1: store data arrives, check linear case
  logic [3*CW-1:0] p0_2_r, c0_2_r, c1_2_r, p1_2_r;
  logic lin_nxt;
  always_ff @(posedge clk) begin
    if (en) c1_r <= c0_nxt;
  end
  always_comb begin
    lin_nxt = c1_r.lin || (p0_q == cc0_q && p1_q == cc1_q);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= '{ok: c1_r.ok, zero: c1_r.zero, end_only: c1_r.end_only, lin: lin_nxt};
      p0_2_r <= p0_q;
      c0_2_r <= cc0_q;
      c1_2_r <= cc1_q;
      p1_2_r <= p1_q;
    end
  end

  // stage 3: products per axis
  logic signed [CW+18:0] pr0_r [3], pr1_r [3], pr2_r [3], pr3_r [3];
  logic signed [CW-1:0] base_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      c3_r <= c2_r;
      for (int a = 0; a < 3; a++) begin
        base_r[a] <= $signed(p0_2_r[a*CW +: CW]);
        if (c2_r.lin || c2_r.end_only) begin
          pr0_r[a] <= ((CW+19)'($signed(p1_2_r[a*CW +: CW]))
                      - (CW+19)'($signed(p0_2_r[a*CW +: CW])))
                      * (CW+19)'($signed({2'b0, t2}));
          pr1_r[a] <= '0; pr2_r[a] <= '0; pr3_r[a] <= '0;
        end else begin
          pr0_r[a] <= (CW+19)'($signed(p0_2_r[a*CW +: CW]))
                      * (CW+19)'($signed({1'b0, w0}));
          pr1_r[a] <= (CW+19)'($signed(c0_2_r[a*CW +: CW]))
                      * (CW+19)'($signed({1'b0, w1}));
          pr2_r[a] <= (CW+19)'($signed(c1_2_r[a*CW +: CW]))
                      * (CW+19)'($signed({1'b0, w2}));
          pr3_r[a] <= (CW+19)'($signed(p1_2_r[a*CW +: CW]))
                      * (CW+19)'($signed({1'b0, w3}));
        end
      end
    end
  end

  // stage 4: sum and output register
  bpe_pkg::out_item_t o_r;
  logic signed [CW+20:0] sum [3];
  logic [CW-1:0] res [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = (CW+21)'(pr0_r[a]) + (CW+21)'(pr1_r[a]) + (CW+21)'(pr2_r[a])
             + (CW+21)'(pr3_r[a]);
      if (c3_r.zero) res[a] = '0;
      else if (c3_r.end_only) res[a] = base_r[a];
      else if (c3_r.lin) res[a] = CW'(base_r[a] + CW'(sum[a] >>> 16));
      else res[a] = CW'(sum[a] >>> 16);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_r.out_x <= res[0];
      o_r.out_y <= res[1];
      o_r.out_z <= res[2];
      o_r.ok <= c3_r.ok;
    end
  end

  assign out_ch.valid = v_r[3];
  assign out_ch.data = o_r;

  `BPE_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(o_r))
  `BPE_ASSERT_IMPL(a_ready, clk, rst_n, !out_ch.valid, in_ch.ready)
  `BPE_ASSERT_IMPL(a_zero, clk, rst_n, out_ch.valid && !o_r.ok, o_r.out_x == 0 && o_r.out_y == 0)
endmodule

### test/bpe_path_checker.sv
// checker for the bezier path point evaluator: predicts every result item
// depends on bpe_pkg; watches both channels and the cfg port
module bpe_path_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  bpe_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  bpe_pkg::out_item_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic cfg_pready,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int fail_count,
  output int pending_count
);
  localparam int NPts = 64;

  logic signed [31:0] pos_tab [NPts*3];
  logic signed [31:0] cin_tab [NPts*3];
  logic signed [31:0] cout_tab [NPts*3];
  logic lin_mode;
  logic wrap_on;
  logic [6:0] pt_count;
  bpe_pkg::out_item_t point_queue [$];

  // floor of a product divided by 2^16
  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic bpe_pkg::out_item_t eval_point(bpe_pkg::in_item_t it);
    bpe_pkg::out_item_t r;
    int cnt, idx, nxt, a;
    longint t, u, uu, tt, w0, w1, w2, w3;
    longint p0, c0, c1, p1, s;
    logic lin, end_only;
    r = '0;
    idx = it.point_index;
    if (it.action == bpe_pkg::ActWrite) begin
      if (it.which_vector != 2'd3) begin
        for (a = 0; a < 3; a++) begin
          case (it.which_vector)
            bpe_pkg::VecPos:
              pos_tab[idx*3+a] = a == 0 ? it.in_x : (a == 1 ? it.in_y : it.in_z);
            bpe_pkg::VecCtrlIn:
              cin_tab[idx*3+a] = a == 0 ? it.in_x : (a == 1 ? it.in_y : it.in_z);
            default:
              cout_tab[idx*3+a] = a == 0 ? it.in_x : (a == 1 ? it.in_y : it.in_z);
          endcase
        end
        r.ok = 1'b1;
      end
      return r;
    end
    cnt = pt_count > NPts ? NPts : pt_count;
    t = it.seg_time > 65536 ? 65536 : it.seg_time;
    if (idx >= cnt) return r;
    r.ok = 1'b1;
    end_only = 1'b0;
    nxt = idx + 1;
    if (idx == cnt - 1) begin
      if (wrap_on) nxt = 0;
      else begin
        end_only = 1'b1;
        nxt = idx;
      end
    end
    lin = lin_mode;
    if (!lin) begin
      lin = 1'b1;
      for (a = 0; a < 3; a++)
        if (pos_tab[idx*3+a] != cout_tab[idx*3+a] || pos_tab[nxt*3+a] != cin_tab[nxt*3+a])
          lin = 1'b0;
    end
    u = 65536 - t;
    uu = (u * u) >>> 16;
    tt = (t * t) >>> 16;
    w0 = (uu * u) >>> 16;
    w1 = (3 * uu * t) >>> 16;
    w2 = (3 * u * tt) >>> 16;
    w3 = (tt * t) >>> 16;
    for (a = 0; a < 3; a++) begin
      p0 = pos_tab[idx*3+a];
      c0 = cout_tab[idx*3+a];
      c1 = cin_tab[nxt*3+a];
      p1 = pos_tab[nxt*3+a];
      if (end_only) s = p0;
      else if (lin) s = p0 + fl16((p1 - p0) * t);
      else s = fl16(w0 * p0 + w1 * c0 + w2 * c1 + w3 * p1);
      case (a)
        0: r.out_x = s[31:0];
        1: r.out_y = s[31:0];
        default: r.out_z = s[31:0];
      endcase
    end
    return r;
  endfunction

  // track register writes, predict accepted items, compare results
  always @(posedge clk) begin
    bpe_pkg::out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      lin_mode <= 1'b0;
      wrap_on <= 1'b0;
      pt_count <= 7'd1;
      point_queue.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          bpe_pkg::RegLinear: lin_mode <= cfg_pwdata[0];
          bpe_pkg::RegWrap: wrap_on <= cfg_pwdata[0];
          bpe_pkg::RegCount: pt_count <= cfg_pwdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) point_queue.push_back(eval_point(in_data));
      if (out_valid && out_ready) begin
        if (point_queue.size() == 0) begin
          $error("unexpected result item x=%0d", out_data.out_x);
          errs++;
        end else begin
          want = point_queue.pop_front();
          if (want.out_x !== out_data.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, out_data.out_x);
            errs++;
          end
          if (want.out_y !== out_data.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, out_data.out_y);
            errs++;
          end
          if (want.out_z !== out_data.out_z) begin
            $error("out_z expected %0d actual %0d", want.out_z, out_data.out_z);
            errs++;
          end
          if (want.ok !== out_data.ok) begin
            $error("ok expected %0d actual %0d", want.ok, out_data.ok);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= point_queue.size();
    end
  end
endmodule

### test/tb_bezier_path_point_eval.sv
// testbench top for the bezier path point evaluator: stimulus and verdict
// depends on bpe_pkg, bpe_stream_if, the block and bpe_path_checker
module tb_bezier_path_point_eval;
  localparam int NPtsTb = 64;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending_count;
  int cur_count;
  logic wrap_cur;
  logic [NPtsTb-1:0] pos_done, cin_done, cout_done;
  int burst_left;

  bpe_stream_if #(.item_t(bpe_pkg::in_item_t)) in_ch (clk);
  bpe_stream_if #(.item_t(bpe_pkg::out_item_t)) out_ch (clk);

  bezier_path_point_eval i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bpe_path_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern: phases of full rate, random and heavy stalls
  initial begin
    int cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      case ((cyc / 300) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #3000000;
    $display("bezier_path_point_eval test failed");
    $finish;
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == bpe_pkg::RegCount) cur_count = val[6:0];
    if (idx == bpe_pkg::RegWrap) wrap_cur = val[0];
  endtask

  // send one item; gaps come from the burst pattern
  task automatic send(input bpe_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.action == bpe_pkg::ActWrite && it.which_vector != 2'd3) begin
      case (it.which_vector)
        bpe_pkg::VecPos: pos_done[it.point_index] = 1'b1;
        bpe_pkg::VecCtrlIn: cin_done[it.point_index] = 1'b1;
        default: cout_done[it.point_index] = 1'b1;
      endcase
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 255) << 16;
      3: return -($urandom_range(0, 255) << 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic bpe_pkg::in_item_t wr_item(int idx, logic [1:0] vec);
    bpe_pkg::in_item_t it;
    it = '0;
    it.action = bpe_pkg::ActWrite;
    it.point_index = 6'(idx);
    it.which_vector = vec;
    it.in_x = rnd_coord();
    it.in_y = rnd_coord();
    it.in_z = rnd_coord();
    it.seg_time = 17'($urandom());
    return it;
  endfunction

  // evaluate item for an index and a segment time; other fields random
  function automatic bpe_pkg::in_item_t ev_item(int idx, logic [16:0] tm);
    bpe_pkg::in_item_t it;
    it = wr_item(idx, 2'($urandom_range(0, 3)));
    it.action = bpe_pkg::ActEval;
    it.seg_time = tm;
    return it;
  endfunction

  function automatic logic safe_eval(int idx);
    int cnt, nxt;
    cnt = cur_count > NPtsTb ? NPtsTb : cur_count;
    if (idx >= cnt) return 1'b1;
    if (!pos_done[idx]) return 1'b0;
    if (idx == cnt - 1 && !wrap_cur) return 1'b1;
    nxt = idx == cnt - 1 ? 0 : idx + 1;
    return pos_done[nxt] && cin_done[nxt] && cout_done[idx];
  endfunction

  function automatic logic [16:0] rnd_time();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return bpe_pkg::TimeOne;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    bpe_pkg::in_item_t it;
    int n, idx, ph;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_count = 1;
    wrap_cur = 1'b0;
    pos_done = '0;
    cin_done = '0;
    cout_done = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill four points, bad selector, evaluate extremes
    reg_write(bpe_pkg::RegCount, 32'd4);
    for (idx = 0; idx < 4; idx++) begin
      send(wr_item(idx, bpe_pkg::VecPos));
      send(wr_item(idx, bpe_pkg::VecCtrlIn));
      send(wr_item(idx, bpe_pkg::VecCtrlOut));
    end
    send(wr_item(5, 2'd3));
    send(ev_item(0, 17'd0));
    send(ev_item(1, bpe_pkg::TimeOne));
    send(ev_item(2, 17'h1ffff));
    send(ev_item(3, 17'd32768));
    send(ev_item(4, 17'd100));
    send(ev_item(63, 17'd100));
    drain();
    reg_write(bpe_pkg::RegWrap, 32'd1);
    reg_write(bpe_pkg::RegLinear, 32'd1);
    send(ev_item(3, 17'd40000));
    send(ev_item(1, 17'd12345));
    drain();
    // collinear controls exercise the linear shortcut in cubic mode
    reg_write(bpe_pkg::RegLinear, 32'd0);
    it = wr_item(0, bpe_pkg::VecPos);
    send(it);
    it.which_vector = bpe_pkg::VecCtrlOut;
    send(it);
    it = wr_item(1, bpe_pkg::VecPos);
    send(it);
    it.which_vector = bpe_pkg::VecCtrlIn;
    send(it);
    send(ev_item(0, 17'd30000));
    drain();

    // random phases over several settings
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: reg_write(bpe_pkg::RegCount, 32'd64);
        1: reg_write(bpe_pkg::RegCount, 32'd1);
        2: reg_write(bpe_pkg::RegCount, 32'd0);
        3: reg_write(bpe_pkg::RegCount, 32'd127);
        default: reg_write(bpe_pkg::RegCount, $urandom_range(2, 64));
      endcase
      reg_write(bpe_pkg::RegWrap, $urandom_range(0, 1));
      reg_write(bpe_pkg::RegLinear, 32'(ph % 4 == 1));
      for (n = 0; n < 125; n++) begin
        idx = $urandom_range(0, 63);
        if ($urandom_range(0, 2) == 0) begin
          send(wr_item(idx, 2'($urandom_range(0, 3))));
        end else if (safe_eval(idx)) begin
          send(ev_item(idx, rnd_time()));
        end else begin
          send(wr_item(idx, 2'($urandom_range(0, 2))));
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("bezier_path_point_eval test passed");
    end else begin
      $display("bezier_path_point_eval test failed");
    end
    $finish;
  end
endmodule
